### sv/lpkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkc_pkg
// Shared types, sizes and operation codes for the linear probing key counter.
// ----------------------------------------------------------------------------
package lpkc_pkg;

  localparam int SLOTS       = 4096;
  localparam int KEY_BITS    = 31;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int MAX_ENTRIES = SLOTS / 2;
  localparam int ORD_BITS    = SLOT_BITS - 1;

  // fixed field widths of the channels
  localparam int MODE_W    = 2;
  localparam int KEY_W     = 31;
  localparam int VALUE_W   = 16;
  localparam int ORDINAL_W = 11;
  localparam int COUNT_W   = 32;
  localparam int HELD_W    = 12;

  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;
  typedef logic [ORD_BITS-1:0]  ord_idx_t;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } slot_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key_out;
    logic [COUNT_W-1:0] count;
    logic               present;
    logic               dropped;
  } result_t;

  // home slot of a key: its low bits
  function automatic slot_idx_t hash_slot(input logic [KEY_W-1:0] k);
    hash_slot = SLOT_BITS'(k);
  endfunction

endpackage

### sv/lpkc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkc_req_if
// Request channel: operation code, key, value and ordinal with valid/ready.
// ----------------------------------------------------------------------------
interface lpkc_req_if
  import lpkc_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [KEY_W-1:0]     key;
  logic [VALUE_W-1:0]   value;
  logic [ORDINAL_W-1:0] ordinal;

  modport source (output valid, mode, key, value, ordinal, input ready);
  modport sink   (input valid, mode, key, value, ordinal, output ready);
endinterface

### sv/lpkc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkc_rsp_if
// Response channel: key, count, flags and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface lpkc_rsp_if
  import lpkc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key_out;
  logic [COUNT_W-1:0] count;
  logic               present;
  logic               dropped;
  logic [HELD_W-1:0]  entries_held;

  modport source (output valid, key_out, count, present, dropped, entries_held,
                  input ready);
  modport sink   (input valid, key_out, count, present, dropped, entries_held,
                  output ready);
endinterface

### sv/linear_probe_key_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_key_counter
// Open-addressing hash table that counts keys, with an insertion-order list.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | mode, key, value, ordinal
//  rsp     | out | valid/ready | key_out, count, present, dropped, entries_held
//
//  insert: reads the home slot, then one further slot per collision (one slot ram
//  read per cycle); read: order ram then slot ram, neither when the ordinal
//  is out of range; clear: frees each held slot through the order list, one
//  slot freed per cycle; unused mode: goes straight to the response.
//  after reset a sweep zeroes all 4096 slots of the slot ram; req.ready stays low.
//  req.ready is high only between transactions; a result waiting on rsp holds
//  the next one in its final cycle until rsp is free.
// ----------------------------------------------------------------------------
module linear_probe_key_counter
  import lpkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lpkc_req_if.sink   req,
  lpkc_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PROBE, S_RD_ORD, S_RD_SLOT, S_CLR, S_OUT
  } state_t;

  state_t               state, state_next;
  slot_idx_t            init_idx, init_idx_next;
  logic [KEY_W-1:0]     op_key, op_key_next;
  logic [VALUE_W-1:0]   op_value, op_value_next;
  slot_idx_t            probe_idx, probe_idx_next;
  logic [SLOT_BITS-1:0] distinct, distinct_next;
  logic [SLOT_BITS-1:0] clr_cnt, clr_cnt_next;
  logic                 clr_pend, clr_pend_next;
  result_t              res, res_next;
  logic                 out_valid;
  result_t              out_res;
  logic [HELD_W-1:0]    out_held;

  // slot ram ports
  slot_t     slot_mem [SLOTS];
  logic      slot_we, slot_re;
  slot_idx_t slot_waddr, slot_raddr;
  slot_t     slot_wdata, slot_q;

  // order ram ports
  slot_idx_t order_mem [MAX_ENTRIES];
  logic      ord_we, ord_re;
  ord_idx_t  ord_waddr, ord_raddr;
  slot_idx_t ord_wdata, order_q;

  logic [KEY_W-1:0]   req_key_m;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat_count;
  logic               out_load;

  assign req_key_m = req.key & KEY_MASK;
  assign sum       = {1'b0, slot_q.count} + (COUNT_W + 1)'(op_value);
  assign sat_count = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign out_load  = (state == S_OUT) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_mem[ord_waddr] <= ord_wdata;
    if (ord_re) order_q <= order_mem[ord_raddr];
  end

  always_comb begin
    state_next     = state;
    init_idx_next  = init_idx;
    op_key_next    = op_key;
    op_value_next  = op_value;
    probe_idx_next = probe_idx;
    distinct_next  = distinct;
    clr_cnt_next   = clr_cnt;
    clr_pend_next  = clr_pend;
    res_next       = res;
    slot_we        = 1'b0;
    slot_waddr     = probe_idx;
    slot_wdata     = '0;
    slot_re        = 1'b0;
    slot_raddr     = probe_idx;
    ord_we         = 1'b0;
    ord_waddr      = distinct[ORD_BITS-1:0];
    ord_wdata      = probe_idx;
    ord_re         = 1'b0;
    ord_raddr      = clr_cnt[ORD_BITS-1:0];

    case (state)
      S_INIT: begin
        slot_we       = 1'b1;
        slot_waddr    = init_idx;
        init_idx_next = init_idx + 1'b1;
        if (init_idx == SLOT_BITS'(SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          op_key_next   = req_key_m;
          op_value_next = req.value;
          res_next      = '0;
          case (req.mode)
            MODE_INSERT: begin
              slot_re        = 1'b1;
              slot_raddr     = hash_slot(req_key_m);
              probe_idx_next = hash_slot(req_key_m);
              state_next     = S_PROBE;
            end
            MODE_READ: begin
              if (32'(req.ordinal) < 32'(distinct)) begin
                ord_re     = 1'b1;
                ord_raddr  = ORD_BITS'(req.ordinal);
                state_next = S_RD_ORD;
              end else begin
                state_next = S_OUT;
              end
            end
            MODE_CLEAR: begin
              clr_cnt_next  = '0;
              clr_pend_next = 1'b0;
              state_next    = S_CLR;
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_PROBE: begin
        if (!slot_q.used) begin
          if (32'(distinct) >= 32'(MAX_ENTRIES)) begin
            res_next = '{key_out: op_key, count: '0, present: 1'b0, dropped: 1'b1};
          end else begin
            slot_we       = 1'b1;
            slot_wdata    = '{used: 1'b1, key: op_key, count: COUNT_W'(op_value)};
            ord_we        = 1'b1;
            distinct_next = distinct + 1'b1;
            res_next      = '{key_out: op_key, count: COUNT_W'(op_value),
                              present: 1'b1, dropped: 1'b0};
          end
          state_next = S_OUT;
        end else if (slot_q.key == op_key) begin
          slot_we    = 1'b1;
          slot_wdata = '{used: 1'b1, key: op_key, count: sat_count};
          res_next   = '{key_out: op_key, count: sat_count, present: 1'b1,
                         dropped: 1'b0};
          state_next = S_OUT;
        end else begin
          // collision: move on to the next slot, wrapping at the end
          probe_idx_next = probe_idx + 1'b1;
          slot_re        = 1'b1;
          slot_raddr     = probe_idx + 1'b1;
        end
      end
      S_RD_ORD: begin
        slot_re    = 1'b1;
        slot_raddr = order_q;
        state_next = S_RD_SLOT;
      end
      S_RD_SLOT: begin
        res_next   = '{key_out: slot_q.key, count: slot_q.count, present: 1'b1,
                       dropped: 1'b0};
        state_next = S_OUT;
      end
      S_CLR: begin
        // order entry read last cycle names a slot to free
        if (clr_pend) begin
          slot_we    = 1'b1;
          slot_waddr = order_q;
        end
        if (clr_cnt < distinct) begin
          ord_re        = 1'b1;
          clr_cnt_next  = clr_cnt + 1'b1;
          clr_pend_next = 1'b1;
        end else begin
          clr_pend_next = 1'b0;
          if (!clr_pend) begin
            distinct_next = '0;
            state_next    = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      distinct  <= '0;
      clr_cnt   <= '0;
      clr_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_idx  <= init_idx_next;
      distinct  <= distinct_next;
      clr_cnt   <= clr_cnt_next;
      clr_pend  <= clr_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    op_key    <= op_key_next;
    op_value  <= op_value_next;
    probe_idx <= probe_idx_next;
    res       <= res_next;
    if (out_load) begin
      out_res  <= res;
      out_held <= HELD_W'(distinct);
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.key_out      = out_res.key_out;
  assign rsp.count        = out_res.count;
  assign rsp.present      = out_res.present;
  assign rsp.dropped      = out_res.dropped;
  assign rsp.entries_held = out_held;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while an operation was in progress");

  a_distinct_bound: assert property (@(posedge clk) disable iff (rst)
    32'(distinct) <= 32'(MAX_ENTRIES))
    else $error("entry count beyond half the slots");

  a_dropped_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.dropped |-> !rsp.present && rsp.count == '0)
    else $error("dropped insert reported as stored");

  a_held_after_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR && state_next == S_OUT |=> distinct == '0)
    else $error("clear left entries counted");

endmodule

### tb/sv/key_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_count_checker
// Watches the request and response channels of the key counter, keeps its
// own copy of the slot table and insertion order, works out the response to
// every accepted request and compares each accepted response, field by field,
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module key_count_checker
  import lpkc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lpkc_req_if  req,
  lpkc_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [KEY_W-1:0]   key_out;
    logic [COUNT_W-1:0] count;
    logic               present;
    logic               dropped;
    logic [HELD_W-1:0]  held;
  } table_result_t;

  logic [KEY_W-1:0]     bucket_key   [SLOTS];
  logic [COUNT_W-1:0]   bucket_count [SLOTS];
  bit                   bucket_taken [SLOTS];
  logic [SLOT_BITS-1:0] arrival_slot [MAX_ENTRIES];
  int unsigned          key_total;

  table_result_t owed_responses [$];
  int            n_fail = 0;

  // applies one request to the shadow table and returns the response it owes
  function automatic table_result_t apply_to_table(input logic [MODE_W-1:0]    m,
                                                   input logic [KEY_W-1:0]     k_in,
                                                   input logic [VALUE_W-1:0]   v,
                                                   input logic [ORDINAL_W-1:0] o);
    table_result_t        r;
    logic [KEY_W-1:0]     k;
    logic [SLOT_BITS-1:0] slot;
    logic [COUNT_W:0]     sum;
    r = '0;
    k = k_in & KEY_MASK;
    case (m)
      MODE_INSERT: begin
        r.key_out = k;
        r.dropped = 1'b1;
        slot = k[SLOT_BITS-1:0];
        for (int n = 0; n < SLOTS; n++) begin
          if (!bucket_taken[slot]) begin
            // a free slot ends the probe; a new key only fits below half full
            if (key_total < MAX_ENTRIES) begin
              bucket_taken[slot]      = 1'b1;
              bucket_key[slot]        = k;
              bucket_count[slot]      = COUNT_W'(v);
              arrival_slot[key_total] = slot;
              key_total++;
              r.count   = COUNT_W'(v);
              r.present = 1'b1;
              r.dropped = 1'b0;
            end
            break;
          end
          if (bucket_key[slot] == k) begin
            sum = {1'b0, bucket_count[slot]} + v;
            bucket_count[slot] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            r.count   = bucket_count[slot];
            r.present = 1'b1;
            r.dropped = 1'b0;
            break;
          end
          slot = slot + 1'b1;
        end
      end
      MODE_READ: begin
        if (o < key_total) begin
          slot      = arrival_slot[o];
          r.key_out = bucket_key[slot];
          r.count   = bucket_count[slot];
          r.present = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < key_total; i++) bucket_taken[arrival_slot[i]] = 1'b0;
        key_total = 0;
      end
      default: begin
      end
    endcase
    r.held = HELD_W'(key_total);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) bucket_taken[i] = 1'b0;
      key_total = 0;
      owed_responses.delete();
    end else begin
      if (req.valid && req.ready)
        owed_responses.push_back(apply_to_table(req.mode, req.key, req.value, req.ordinal));
      if (rsp.valid && rsp.ready) begin
        if (owed_responses.size() == 0) begin
          $error("response with no transaction outstanding: key_out %0h count %0h",
                 rsp.key_out, rsp.count);
          n_fail++;
        end else begin
          want = owed_responses.pop_front();
          compare_field("key_out", 32'(want.key_out), 32'(rsp.key_out));
          compare_field("count", want.count, rsp.count);
          compare_field("present", 32'(want.present), 32'(rsp.present));
          compare_field("dropped", 32'(want.dropped), 32'(rsp.dropped));
          compare_field("entries_held", 32'(want.held), 32'(rsp.entries_held));
        end
      end
    end
    fail_count <= n_fail;
    pending    <= owed_responses.size();
  end

endmodule

### tb/sv/tb_linear_probe_key_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_key_counter
// Drives the key counter through directed corner cases, a fill to the
// half-full limit and a random mix of all four modes over
// clustered keys, with bursty requests and a stalling response side. The
// checker instance does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_linear_probe_key_counter;
  import lpkc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;

  localparam int RANDOM_ITEMS   = 300;
  localparam int POOL_SIZE      = 48;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 64;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   burst_left   = 0;
  int   hold_asks    = 0;
  int   quiet_cycles = 0;

  lpkc_req_if req_if ();
  lpkc_rsp_if rsp_if ();

  linear_probe_key_counter dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  key_count_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offers one request and returns once it has been taken; idles between bursts
  task automatic send_op(input logic [MODE_W-1:0]    m,
                         input logic [KEY_W-1:0]     k,
                         input logic [VALUE_W-1:0]   v,
                         input logic [ORDINAL_W-1:0] o);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= m;
    req_if.key     <= k;
    req_if.value   <= v;
    req_if.ordinal <= o;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    burst_left--;
  endtask

  // response side: changing stall patterns, plus a long hold-off on request
  initial begin
    int style;
    int style_left;
    int holds_done;
    int tick;
    style      = 0;
    style_left = 0;
    holds_done = 0;
    tick       = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        tick++;
        case (style)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= (tick % 4 == 0);
          default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("linear_probe_key_counter regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0]     pool [POOL_SIZE];
    logic [KEY_W-1:0]     k;
    logic [KEY_W-1:0]     first_key;
    logic [VALUE_W-1:0]   v;
    logic [ORDINAL_W-1:0] o;
    int                   pick;
    rst            <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.mode    <= MODE_INSERT;
    req_if.key     <= '0;
    req_if.value   <= '0;
    req_if.ordinal <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corner cases: empty read, extreme keys and values, probe wrapping past
    // the top slot, accumulation, out-of-range reads, the unused mode, clear
    send_op(MODE_READ, '0, '0, '0);
    send_op(MODE_INSERT, '0, '0, '0);
    send_op(MODE_INSERT, '1, '1, '1);
    send_op(MODE_INSERT, 31'h0000_0fff, 16'd1, '0);
    send_op(MODE_INSERT, '1, '1, '0);
    send_op(MODE_INSERT, 31'h0000_1000, 16'd7, '0);
    send_op(MODE_INSERT, '0, 16'd1, '0);
    for (int i = 0; i < 5; i++) send_op(MODE_READ, '1, '1, 11'(i));
    send_op(MODE_READ, '0, '0, '1);
    send_op(MODE_IDLE, '1, '1, '1);
    send_op(MODE_CLEAR, '1, '1, '1);
    send_op(MODE_READ, '0, '0, '0);
    send_op(MODE_INSERT, 31'h5555_5555, 16'haaaa, '0);
    send_op(MODE_READ, '0, '0, '0);
    send_op(MODE_IDLE, 31'($urandom), 16'($urandom), 11'($urandom));

    // fill to the half-full limit; low bits keep fill keys distinct, bit 30
    // keeps the refused keys apart from them
    send_op(MODE_CLEAR, '0, '0, '0);
    hold_asks <= hold_asks + 1;
    first_key = {1'b0, 19'($urandom), 11'd0};
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      k = (i == 0) ? first_key : {1'b0, 19'($urandom), 11'(i)};
      send_op(MODE_INSERT, k, 16'($urandom), 11'($urandom));
    end
    for (int i = 0; i < 4; i++) send_op(MODE_INSERT, {1'b1, 30'($urandom)}, 16'($urandom), '0);
    send_op(MODE_INSERT, first_key, '1, '0);
    send_op(MODE_READ, '0, '0, 11'(MAX_ENTRIES - 1));
    send_op(MODE_READ, '0, '0, '0);
    send_op(MODE_IDLE, '0, '0, '0);
    send_op(MODE_CLEAR, '0, '0, '0);

    // random mix over a pool of keys whose home slots straddle the table end
    for (int i = 0; i < POOL_SIZE; i++)
      pool[i] = {19'($urandom), 12'((4090 + $urandom_range(0, 11)) % SLOTS)};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) hold_asks <= hold_asks + 1;
      pick = $urandom_range(0, 99);
      k    = 31'($urandom);
      v    = 16'($urandom);
      o    = 11'($urandom);
      if (pick < 55)
        send_op(MODE_INSERT, pool[$urandom_range(0, POOL_SIZE - 1)],
                ($urandom_range(0, 3) != 0) ? 16'd1 : v, o);
      else if (pick < 65)
        send_op(MODE_INSERT, k, v, o);
      else if (pick < 91)
        send_op(MODE_READ, k, v, 11'($urandom_range(0, 63)));
      else if (pick < 95)
        send_op(MODE_READ, k, v, o);
      else if (pick < 98)
        send_op(MODE_IDLE, k, v, o);
      else
        send_op(MODE_CLEAR, k, v, o);
    end
    req_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("linear_probe_key_counter regression: pass");
    end else begin
      $display("linear_probe_key_counter regression: fail");
    end
    $finish;
  end

endmodule
